// ===== rtl/assert_macros.svh =====
// assertion helpers, sampled on clk and off while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds in the same cycle as its condition
`define ASSERT_AT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// property that holds in the cycle after its condition
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/grms_pkg.sv =====
`timescale 1ns / 1ps

package grms_pkg;

    localparam int TRIALS_DEF = 16;
    localparam int SUM_W      = 50;
    localparam int CNT_W      = 16;
    localparam int VAL_W      = 17;
    localparam int SQ_W       = 2 * VAL_W;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_FINISH = 1'b1;

    localparam logic [1:0] KIND_RMS  = 2'd0;
    localparam logic [1:0] KIND_MEAN = 2'd1;
    localparam logic [1:0] KIND_STD  = 2'd2;

    localparam logic [1:0] SRC_TRIAL = 2'd0;
    localparam logic [1:0] SRC_MEAN  = 2'd1;
    localparam logic [1:0] SRC_STD   = 2'd2;

    typedef struct packed {
        logic       capture;
        logic       rd_idx;
        logic       sample_rd;
        logic       sample_wr;
        logic       div_start;
        logic [1:0] div_src;
        logic       sqrt_start;
        logic       acc_r;
        logic       acc_q;
        logic       std_mul;
        logic       std_sub;
        logic       emit;
        logic [1:0] emit_kind;
        logic       emit_few;
        logic       emit_last;
        logic       clear;
        logic       idx_inc;
    } cmd_t;

    typedef struct packed {
        logic out_busy;
        logic rd_vld;
        logic div_busy;
        logic sqrt_busy;
        logic idx_last;
        logic n_zero;
        logic n_small;
    } stat_t;

endpackage

// ===== rtl/grms_ctrl.sv =====
`timescale 1ns / 1ps

module grms_ctrl
    import grms_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  req_valid,
    output logic  req_ready,
    input  logic  req_type,
    input  stat_t stat,
    output cmd_t  cmd
);

    localparam logic [4:0] ST_IDLE   = 5'd0;
    localparam logic [4:0] ST_S_RD   = 5'd1;
    localparam logic [4:0] ST_S_UPD  = 5'd2;
    localparam logic [4:0] ST_F_RD   = 5'd3;
    localparam logic [4:0] ST_F_CHK  = 5'd4;
    localparam logic [4:0] ST_F_DIV  = 5'd5;
    localparam logic [4:0] ST_F_SQRT = 5'd6;
    localparam logic [4:0] ST_F_ACC  = 5'd7;
    localparam logic [4:0] ST_F_EMIT = 5'd8;
    localparam logic [4:0] ST_M_CHK  = 5'd9;
    localparam logic [4:0] ST_M_DIV  = 5'd10;
    localparam logic [4:0] ST_M_EMIT = 5'd11;
    localparam logic [4:0] ST_T_MUL  = 5'd12;
    localparam logic [4:0] ST_T_SUB  = 5'd13;
    localparam logic [4:0] ST_T_DST  = 5'd14;
    localparam logic [4:0] ST_T_DIV  = 5'd15;
    localparam logic [4:0] ST_T_SQRT = 5'd16;
    localparam logic [4:0] ST_T_EMIT = 5'd17;
    localparam logic [4:0] ST_CLR    = 5'd18;

    logic [4:0] state_reg;
    logic [4:0] state_next;

    assign req_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = (req_type == REQ_FINISH) ? ST_F_RD : ST_S_RD;
                end
            end
            ST_S_RD:
            begin
                cmd.sample_rd = 1'b1;
                state_next    = ST_S_UPD;
            end
            ST_S_UPD:
            begin
                cmd.sample_wr = 1'b1;
                state_next    = ST_IDLE;
            end
            ST_F_RD:
            begin
                cmd.rd_idx = 1'b1;
                state_next = ST_F_CHK;
            end
            ST_F_CHK:
            begin
                if (stat.rd_vld)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_src   = SRC_TRIAL;
                    state_next    = ST_F_DIV;
                end
                else if (stat.idx_last)
                begin
                    state_next = ST_M_CHK;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_F_RD;
                end
            end
            ST_F_DIV:
            begin
                if (!stat.div_busy)
                begin
                    cmd.sqrt_start = 1'b1;
                    state_next     = ST_F_SQRT;
                end
            end
            ST_F_SQRT:
            begin
                if (!stat.sqrt_busy)
                begin
                    cmd.acc_r  = 1'b1;
                    state_next = ST_F_ACC;
                end
            end
            ST_F_ACC:
            begin
                cmd.acc_q  = 1'b1;
                state_next = ST_F_EMIT;
            end
            ST_F_EMIT:
            begin
                if (!stat.out_busy)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = KIND_RMS;
                    if (stat.idx_last)
                    begin
                        state_next = ST_M_CHK;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = ST_F_RD;
                    end
                end
            end
            ST_M_CHK:
            begin
                if (stat.n_zero)
                begin
                    state_next = ST_M_EMIT;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_src   = SRC_MEAN;
                    state_next    = ST_M_DIV;
                end
            end
            ST_M_DIV:
            begin
                if (!stat.div_busy)
                begin
                    state_next = ST_M_EMIT;
                end
            end
            ST_M_EMIT:
            begin
                if (!stat.out_busy)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = KIND_MEAN;
                    cmd.emit_few  = stat.n_zero;
                    state_next    = stat.n_small ? ST_T_EMIT : ST_T_MUL;
                end
            end
            ST_T_MUL:
            begin
                cmd.std_mul = 1'b1;
                state_next  = ST_T_SUB;
            end
            ST_T_SUB:
            begin
                cmd.std_sub = 1'b1;
                state_next  = ST_T_DST;
            end
            ST_T_DST:
            begin
                cmd.div_start = 1'b1;
                cmd.div_src   = SRC_STD;
                state_next    = ST_T_DIV;
            end
            ST_T_DIV:
            begin
                if (!stat.div_busy)
                begin
                    cmd.sqrt_start = 1'b1;
                    state_next     = ST_T_SQRT;
                end
            end
            ST_T_SQRT:
            begin
                if (!stat.sqrt_busy)
                begin
                    state_next = ST_T_EMIT;
                end
            end
            ST_T_EMIT:
            begin
                if (!stat.out_busy)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = KIND_STD;
                    cmd.emit_few  = stat.n_small;
                    cmd.emit_last = 1'b1;
                    state_next    = ST_CLR;
                end
            end
            ST_CLR:
            begin
                cmd.clear  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/grms_dp.sv =====
`timescale 1ns / 1ps

module grms_dp
    import grms_pkg::*;
#(
    parameter int TRIALS = TRIALS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cmd_t                    cmd,
    output stat_t                   stat,
    input  logic                    req_type,
    input  logic signed [15:0]      reference,
    input  logic signed [15:0]      measured,
    input  logic [3:0]              trial,
    output logic                    res_valid,
    input  logic                    res_ready,
    output logic [1:0]              kind,
    output logic [3:0]              trial_number,
    output logic [VAL_W-1:0]        value,
    output logic                    too_few,
    output logic                    last
);

    localparam int AW    = $clog2(TRIALS);
    localparam int NW    = $clog2(TRIALS + 1);
    localparam int SW    = VAL_W + NW;
    localparam int QW    = SQ_W + NW;
    localparam int W2    = 2 * SW;
    localparam int DCW   = $clog2(SUM_W + 1);
    localparam int SQ_TOP = SUM_W - 2;

    // sample store
    logic [SUM_W-1:0]  sum_mem [TRIALS];
    logic [CNT_W-1:0]  cnt_mem [TRIALS];
    logic [TRIALS-1:0] vld_reg;

    logic              type_reg;
    logic signed [15:0] ref_reg;
    logic signed [15:0] meas_reg;
    logic [3:0]        trial_reg;

    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;
    logic [SUM_W-1:0]  rd_sum_reg;
    logic [CNT_W-1:0]  rd_cnt_reg;
    logic              rd_vld_reg;
    logic [SQ_W-1:0]   sq_reg;

    logic signed [16:0] err;
    logic [16:0]       mag;
    logic [SUM_W-1:0]  base_sum;
    logic [CNT_W-1:0]  base_cnt;
    logic              in_range;
    logic              do_write;

    // accumulators
    logic [AW-1:0]     idx_reg;
    logic [NW-1:0]     n_reg;
    logic [SW-1:0]     s_reg;
    logic [QW-1:0]     q_reg;
    logic [SQ_W-1:0]   rr_reg;
    logic [W2-1:0]     nq_reg;
    logic [W2-1:0]     ss_reg;
    logic [SUM_W-1:0]  num_reg;
    logic [CNT_W-1:0]  den_reg;
    logic [2*NW-1:0]   nn_prod;
    logic [VAL_W-1:0]  r_val;

    // shared divider
    logic              div_busy_reg;
    logic [DCW-1:0]    div_cnt_reg;
    logic [SUM_W-1:0]  div_quo_reg;
    logic [CNT_W:0]    div_rem_reg;
    logic [CNT_W-1:0]  div_den_reg;
    logic [CNT_W:0]    div_sh;
    logic              div_ge;
    logic [SUM_W-1:0]  div_a;
    logic [CNT_W-1:0]  div_b;

    // shared square root
    logic              sq_busy_reg;
    logic [SUM_W-1:0]  sq_x_reg;
    logic [SUM_W-1:0]  sq_res_reg;
    logic [SUM_W-1:0]  sq_bit_reg;
    logic [SUM_W-1:0]  sq_t;

    // result register
    logic              res_valid_reg;
    logic [1:0]        kind_reg;
    logic [3:0]        tnum_reg;
    logic [VAL_W-1:0]  value_reg;
    logic              few_reg;
    logic              last_reg;

    assign err      = {ref_reg[15], ref_reg} - {meas_reg[15], meas_reg};
    assign mag      = err[16] ? 17'(-err) : 17'(err);
    assign wr_addr  = AW'(trial_reg);
    assign rd_addr  = cmd.rd_idx ? idx_reg : wr_addr;
    assign in_range = (32'(trial_reg) < TRIALS);
    assign base_sum = rd_vld_reg ? rd_sum_reg : '0;
    assign base_cnt = rd_vld_reg ? rd_cnt_reg : '0;
    assign do_write = cmd.sample_wr && (type_reg == REQ_SAMPLE) && in_range
                      && (base_cnt != CNT_MAX);
    assign r_val    = sq_res_reg[VAL_W-1:0];
    assign nn_prod  = {{NW{1'b0}}, n_reg} * {{NW{1'b0}}, n_reg - NW'(1)};

    always_comb
    begin
        case (cmd.div_src)
            SRC_TRIAL:
            begin
                div_a = base_sum;
                div_b = base_cnt;
            end
            SRC_MEAN:
            begin
                div_a = SUM_W'(s_reg);
                div_b = CNT_W'(n_reg);
            end
            SRC_STD:
            begin
                div_a = num_reg;
                div_b = den_reg;
            end
            default:
            begin
                div_a = '0;
                div_b = '0;
            end
        endcase
    end

    assign div_sh = {div_rem_reg[CNT_W-1:0], div_quo_reg[SUM_W-1]};
    assign div_ge = (div_sh >= {1'b0, div_den_reg});
    assign sq_t   = sq_res_reg + sq_bit_reg;

    assign stat.out_busy  = res_valid_reg;
    assign stat.rd_vld    = rd_vld_reg;
    assign stat.div_busy  = div_busy_reg;
    assign stat.sqrt_busy = sq_busy_reg;
    assign stat.idx_last  = (idx_reg == AW'(TRIALS - 1));
    assign stat.n_zero    = (n_reg == '0);
    assign stat.n_small   = (n_reg < NW'(2));

    // memory, no reset
    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            sum_mem[wr_addr] <= SUM_W'(base_sum + SUM_W'(sq_reg));
            cnt_mem[wr_addr] <= base_cnt + CNT_W'(1);
        end
        rd_sum_reg <= sum_mem[rd_addr];
        rd_cnt_reg <= cnt_mem[rd_addr];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            type_reg  <= req_type;
            ref_reg   <= reference;
            meas_reg  <= measured;
            trial_reg <= trial;
        end
        if (cmd.sample_rd)
        begin
            sq_reg <= SQ_W'(mag) * SQ_W'(mag);
        end
        if (cmd.acc_r)
        begin
            rr_reg <= SQ_W'(r_val) * SQ_W'(r_val);
        end
        if (cmd.std_mul)
        begin
            nq_reg <= W2'(n_reg) * W2'(q_reg);
            ss_reg <= W2'(s_reg) * W2'(s_reg);
        end
        if (cmd.std_sub)
        begin
            num_reg <= SUM_W'(nq_reg - ss_reg);
            den_reg <= CNT_W'(nn_prod);
        end
        if (cmd.div_start)
        begin
            div_quo_reg <= div_a;
            div_rem_reg <= '0;
            div_den_reg <= div_b;
        end
        else if (div_busy_reg)
        begin
            div_rem_reg <= div_ge ? (div_sh - {1'b0, div_den_reg}) : div_sh;
            div_quo_reg <= {div_quo_reg[SUM_W-2:0], div_ge};
        end
        if (cmd.sqrt_start)
        begin
            sq_x_reg   <= div_quo_reg;
            sq_res_reg <= '0;
            sq_bit_reg <= SUM_W'(1) << SQ_TOP;
        end
        else if (sq_busy_reg)
        begin
            if (sq_x_reg >= sq_t)
            begin
                sq_x_reg   <= sq_x_reg - sq_t;
                sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
            end
            else
            begin
                sq_res_reg <= sq_res_reg >> 1;
            end
            sq_bit_reg <= sq_bit_reg >> 2;
        end
        if (cmd.emit)
        begin
            kind_reg <= cmd.emit_kind;
            tnum_reg <= (cmd.emit_kind == KIND_RMS) ? 4'(idx_reg) : 4'd0;
            few_reg  <= cmd.emit_few;
            last_reg <= cmd.emit_last;
            if (cmd.emit_few)
            begin
                value_reg <= '0;
            end
            else if (cmd.emit_kind == KIND_MEAN)
            begin
                value_reg <= div_quo_reg[VAL_W-1:0];
            end
            else
            begin
                value_reg <= r_val;
            end
        end
    end

    // control state and accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            idx_reg       <= '0;
            n_reg         <= '0;
            s_reg         <= '0;
            q_reg         <= '0;
            div_busy_reg  <= 1'b0;
            div_cnt_reg   <= '0;
            sq_busy_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= vld_reg[rd_addr];
            if (do_write)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + AW'(1);
            end
            if (cmd.acc_r)
            begin
                s_reg <= s_reg + SW'(r_val);
                n_reg <= n_reg + NW'(1);
            end
            if (cmd.acc_q)
            begin
                q_reg <= q_reg + QW'(rr_reg);
            end
            if (cmd.clear)
            begin
                vld_reg <= '0;
                idx_reg <= '0;
                n_reg   <= '0;
                s_reg   <= '0;
                q_reg   <= '0;
            end
            if (cmd.div_start)
            begin
                div_busy_reg <= 1'b1;
                div_cnt_reg  <= DCW'(SUM_W);
            end
            else if (div_busy_reg)
            begin
                div_cnt_reg <= div_cnt_reg - DCW'(1);
                if (div_cnt_reg == DCW'(1))
                begin
                    div_busy_reg <= 1'b0;
                end
            end
            if (cmd.sqrt_start)
            begin
                sq_busy_reg <= 1'b1;
            end
            else if (sq_busy_reg && sq_bit_reg[0])
            begin
                sq_busy_reg <= 1'b0;
            end
            if (cmd.emit)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    assign res_valid    = res_valid_reg;
    assign kind         = kind_reg;
    assign trial_number = tnum_reg;
    assign value        = value_reg;
    assign too_few      = few_reg;
    assign last         = last_reg;

endmodule

// ===== rtl/grouped_rms_error_statistics.sv =====
`timescale 1ns / 1ps
// grouped rms error statistics
// request channel (req_valid / req_ready) takes one beat per item: a sample
// (req_type 0) with reference, measured and trial, or a finish (req_type 1).
// result channel (res_valid / res_ready) returns kind, trial_number, value,
// too_few and last; a sample gives no result beat.
// a sample is accepted, then the table is read and the error squared, then
// the trial's sum and count get their read-modify-write; no new request is
// taken until that is done. a finish walks the trials one by one: an empty
// trial is only read and checked, a trial with samples goes through the
// 50-step divider and the 25-step square root, then accumulate and emit;
// then mean and std follow, plus a clear step, all through the one shared
// divider and square root unit.
// results are held in an output register; while the receiver stalls the
// sequencer waits at the next emit and no new request is taken until the
// finish run is done. after the last (std) beat is loaded all trial data is
// cleared by the clear step.
// reset clears the trial valid bits, so every trial starts at zero at once;
// no clearing pass over the tables is needed.

module grouped_rms_error_statistics
    import grms_pkg::*;
#(
    parameter int TRIALS = TRIALS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  logic               req_type,
    input  logic signed [15:0] reference,
    input  logic signed [15:0] measured,
    input  logic [3:0]         trial,
    output logic               res_valid,
    input  logic               res_ready,
    output logic [1:0]         kind,
    output logic [3:0]         trial_number,
    output logic [VAL_W-1:0]   value,
    output logic               too_few,
    output logic               last
);

`include "assert_macros.svh"

    cmd_t  cmd;
    stat_t stat;

    // sequencer
    grms_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_type  (req_type),
        .stat      (stat),
        .cmd       (cmd)
    );

    // tables, arithmetic units and result register
    grms_dp #(
        .TRIALS (TRIALS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .req_type     (req_type),
        .reference    (reference),
        .measured     (measured),
        .trial        (trial),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .kind         (kind),
        .trial_number (trial_number),
        .value        (value),
        .too_few      (too_few),
        .last         (last)
    );

    // a finish beat keeps the request side closed on the next cycle
    `ASSERT_NEXT(a_finish_busy, req_valid && req_ready && (req_type == REQ_FINISH),
        !req_ready, "request taken right after a finish")
    // the last beat of a run is always the std result
    `ASSERT_AT(a_last_is_std, res_valid && last, kind == KIND_STD,
        "last beat is not a std result")
    // a too_few result carries zero
    `ASSERT_AT(a_few_zero, res_valid && too_few, value == '0,
        "too_few result with nonzero value")
    // trial results never carry the too_few or the last flag
    `ASSERT_AT(a_rms_flags, res_valid && (kind == KIND_RMS), !too_few && !last,
        "trial result with flags set")

endmodule
